// ===== rtl/core/iwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// iwmm_pkg
// Shared types and constants of the IUPAC window mismatch matcher.
// ----------------------------------------------------------------------------
package iwmm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned PosW       = $clog2(MaxPattern);
  localparam int unsigned LenW       = 6;
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned MaskW      = 4;
  localparam int unsigned NibbleW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength = 3'd0,
    CfgMismatchLimit = 3'd1,
    CfgMasksLow      = 3'd2,
    CfgMasksHigh     = 3'd3,
    CfgConserved     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       record_start;
    logic [1:0] base_code;
    logic       base_valid;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] window_start;
    logic              forward_hit;
    logic [LenW-1:0]   forward_mismatches;
    logic              reverse_hit;
    logic [LenW-1:0]   reverse_mismatches;
  } out_t;

  typedef logic [MaxPattern-1:0][1:0]       seq_t;
  typedef logic [MaxPattern-1:0][MaskW-1:0] mask_arr_t;

  typedef struct packed {
    logic            hit;
    logic [LenW-1:0] mismatches;
  } cmp_res_t;

endpackage

// ===== rtl/core/iwmm_strand_cmp.sv =====
// ----------------------------------------------------------------------------
// iwmm_strand_cmp
// Compares one strand against the pattern masks: conserved check and
// mismatch count over the enabled positions.
// ----------------------------------------------------------------------------
module iwmm_strand_cmp (
  input  iwmm_pkg::seq_t                      seq_i,
  input  logic [iwmm_pkg::MaxPattern-1:0]     pos_en_i,
  input  iwmm_pkg::mask_arr_t                 masks_i,
  input  logic [iwmm_pkg::MaxPattern-1:0]     conserved_i,
  input  logic [iwmm_pkg::LenW-1:0]           limit_i,
  output iwmm_pkg::cmp_res_t                  res_o
);
  import iwmm_pkg::*;

  localparam int unsigned NumNibbles = MaxPattern / 4;

  logic [MaxPattern-1:0]                miss;
  logic [MaxPattern-1:0]                mis_vec;
  logic                                 cons_fail;
  logic [NumNibbles-1:0][NibbleW-1:0]   nib_cnt;
  logic [LenW-1:0]                      total;

  always_comb begin
    for (int p = 0; p < MaxPattern; p++) begin
      miss[p] = pos_en_i[p] & ~masks_i[p][seq_i[p]];
    end
    mis_vec   = miss & ~conserved_i;
    cons_fail = |(miss & conserved_i);
  end

  // two-level count: per nibble, then across nibbles
  always_comb begin
    for (int n = 0; n < NumNibbles; n++) begin
      nib_cnt[n] = NibbleW'(mis_vec[4*n]) + NibbleW'(mis_vec[4*n+1])
                 + NibbleW'(mis_vec[4*n+2]) + NibbleW'(mis_vec[4*n+3]);
    end
    total = '0;
    for (int n = 0; n < NumNibbles; n++) begin
      total = total + LenW'(nib_cnt[n]);
    end
  end

  assign res_o.mismatches = total;
  assign res_o.hit        = ~cons_fail & (total <= limit_i);

endmodule

// ===== rtl/core/iupac_window_mismatch_matcher.sv =====
// ----------------------------------------------------------------------------
// iupac_window_mismatch_matcher
// Streams sequence bases through a 32-deep window and matches the newest
// pattern_length bases, forward and reverse complement, against an IUPAC
// pattern with a mismatch budget.
//
// Usage:
//   in channel  : one base or a record-start marker per request
//                 (in_valid_i / in_ready_o / in_data_i)
//   out channel : one request per window that hits on either strand
//                 (out_valid_o / out_ready_i / out_data_o)
//   cfg port    : cfg_we_i writes cfg_data_i to the register at cfg_idx_i;
//                 write only while no base is in flight
// Throughput: one base per cycle while the receiver does not stall; the
// window shift register feeds the two strand comparators, whose outputs
// land in the result register. A record-start request clears the window
// and the base count and gives no result. When the receiver stalls, the
// result register holds and one more base is taken into the window
// stage; after that in_ready_o drops.
// Reset clears the window, the count and the configuration to defaults.
// ----------------------------------------------------------------------------
module iupac_window_mismatch_matcher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  iwmm_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output iwmm_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [iwmm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [iwmm_pkg::CfgDataW-1:0]      cfg_data_i
);
  import iwmm_pkg::*;

  // configuration
  logic [LenW-1:0]         len_q;
  logic [LenW-1:0]         limit_q;
  logic [2*CfgDataW-1:0]   masks_q;
  logic [MaxPattern-1:0]   cons_q;
  logic [LenW-1:0]         len_wr;

  // window stage
  seq_t                    win_q;
  logic [MaxPattern-1:0]   win_valid_q;
  logic [CountW-1:0]       count_q;
  logic                    eval_q;

  // result stage
  logic                    out_valid_q;
  out_t                    out_q;

  logic                    in_acc;
  logic                    advance;
  logic [MaxPattern-1:0]   pos_en;
  logic                    all_valid;
  seq_t                    fwd_seq;
  seq_t                    rev_seq;
  mask_arr_t               masks;
  cmp_res_t                fwd_res;
  cmp_res_t                rev_res;
  logic                    fwd_hit;
  logic                    rev_hit;
  logic [PosW-1:0]         fwd_idx;

  assign advance    = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~eval_q | advance;
  assign in_acc     = in_valid_i & in_ready_o;

  // length clamp at write time
  always_comb begin
    if (cfg_data_i[LenW-1:0] == '0) begin
      len_wr = LenW'(1);
    end else if (cfg_data_i[LenW-1:0] > LenW'(MaxPattern)) begin
      len_wr = LenW'(MaxPattern);
    end else begin
      len_wr = cfg_data_i[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LenW'(1);
      limit_q <= '0;
      masks_q <= '1;
      cons_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatternLength: len_q                        <= len_wr;
        CfgMismatchLimit: limit_q                      <= cfg_data_i[LenW-1:0];
        CfgMasksLow:      masks_q[CfgDataW-1:0]        <= cfg_data_i;
        CfgMasksHigh:     masks_q[2*CfgDataW-1:CfgDataW] <= cfg_data_i;
        CfgConserved:     cons_q                       <= cfg_data_i[MaxPattern-1:0];
        default: ;
      endcase
    end
  end

  // window shift register, index 0 is the newest base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= '0;
      count_q     <= '0;
      eval_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        eval_q <= ~in_data_i.record_start;
        if (in_data_i.record_start) begin
          win_valid_q <= '0;
          count_q     <= '0;
        end else begin
          win_valid_q <= {win_valid_q[MaxPattern-2:0], in_data_i.base_valid};
          count_q     <= count_q + CountW'(1);
        end
      end else if (advance) begin
        eval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !in_data_i.record_start) begin
      win_q <= {win_q[MaxPattern-2:0], in_data_i.base_code};
    end
  end

  // strand alignment
  assign masks = mask_arr_t'(masks_q);

  always_comb begin
    for (int p = 0; p < MaxPattern; p++) begin
      pos_en[p] = LenW'(p) < len_q;
    end
    all_valid = &(win_valid_q | ~pos_en);
  end

  always_comb begin
    fwd_idx = '0;
    for (int p = 0; p < MaxPattern; p++) begin
      fwd_idx    = PosW'(len_q - LenW'(1) - LenW'(p));
      fwd_seq[p] = win_q[fwd_idx];
      rev_seq[p] = ~win_q[p];
    end
  end

  iwmm_strand_cmp u_fwd_cmp (
    .seq_i       (fwd_seq),
    .pos_en_i    (pos_en),
    .masks_i     (masks),
    .conserved_i (cons_q),
    .limit_i     (limit_q),
    .res_o       (fwd_res)
  );

  iwmm_strand_cmp u_rev_cmp (
    .seq_i       (rev_seq),
    .pos_en_i    (pos_en),
    .masks_i     (masks),
    .conserved_i (cons_q),
    .limit_i     (limit_q),
    .res_o       (rev_res)
  );

  assign fwd_hit = all_valid & fwd_res.hit;
  assign rev_hit = all_valid & rev_res.hit;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= eval_q & (fwd_hit | rev_hit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && eval_q) begin
      out_q.window_start       <= count_q - CountW'(len_q);
      out_q.forward_hit        <= fwd_hit;
      out_q.forward_mismatches <= fwd_res.mismatches;
      out_q.reverse_hit        <= rev_hit;
      out_q.reverse_mismatches <= rev_res.mismatches;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // assertions
  a_out_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.forward_hit || out_data_o.reverse_hit))
    else $error("result without a hit");

  a_fwd_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.forward_hit) |-> (out_data_o.forward_mismatches <= limit_q))
    else $error("forward hit over mismatch limit");

  a_rev_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reverse_hit) |-> (out_data_o.reverse_mismatches <= limit_q))
    else $error("reverse hit over mismatch limit");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (eval_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a downstream stall");

  a_record_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.record_start) |=> (win_valid_q == '0 && count_q == '0 && !eval_q))
    else $error("record start did not clear the window");

endmodule
